// ===== sv/vertex_projection_divide_defines.svh =====
// assertion macros for the vertex projection divide block
// included by the modules that carry assertions
`ifndef VERTEX_PROJECTION_DIVIDE_DEFINES_SVH
`define VERTEX_PROJECTION_DIVIDE_DEFINES_SVH
`ifndef ASSERT_OFF
`define VPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VPD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define VPD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/vpd_pkg.sv =====
// package for the vertex projection divide block
// constants and word types; no dependencies
package vpd_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 66;                  // exact dot product width
    localparam int DIV_W     = NUM_W + FRAC_BITS;   // shifted numerator width
    localparam int QSTEPS    = 4;                   // quotient bits per divider stage
    localparam int DIV_STG   = (DIV_W + QSTEPS - 1) / QSTEPS;
    localparam int DIV_PAD   = DIV_STG * QSTEPS;
    localparam int CNT_W     = $clog2(DIV_PAD + 1);

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_PROJECT = 1'b1
    } t_action;

    typedef struct packed {
        logic        action;
        logic [3:0]  coef_index;
        logic [31:0] coef_value;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
    } t_in_word;

    typedef struct packed {
        logic [31:0] proj_x;
        logic [31:0] proj_y;
        logic [31:0] proj_z;
        logic        divide_by_zero;
        logic        saturated;
    } t_out_word;

    // per-lane divider state carried between stages
    typedef struct packed {
        logic [DIV_PAD-1:0] num;
        logic [NUM_W:0]     rem;
        logic [DIV_PAD-1:0] quo;
        logic               neg;
    } t_div_lane;

    // sideband that travels with each divider word
    typedef struct packed {
        logic               dz;
        logic [NUM_W-1:0]   den;
    } t_div_side;
endpackage

// ===== sv/vpd_if.sv =====
// valid/ready channel for the vertex projection divide block
// depends on vpd_pkg
interface vpd_in_if import vpd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vpd_out_if import vpd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/vpd_dot.sv =====
// coefficient table and dot product stages
// depends on vpd_pkg; feeds vpd_div
`include "vertex_projection_divide_defines.svh"
module vpd_dot import vpd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_in_word                i_word,
    output logic                    o_valid,
    output logic signed [NUM_W-1:0] o_n [3],
    output logic signed [NUM_W-1:0] o_w
);
    logic [31:0] r_tab [16];
    logic        r_v1, r_v2;
    logic signed [63:0] r_prod [4][3];
    logic signed [31:0] r_m33;
    logic signed [NUM_W-1:0] r_n [3];
    logic signed [NUM_W-1:0] r_w;
    logic is_proj;

    assign is_proj = (i_word.action == ACT_PROJECT);

    // table writes on load words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_tab[i] <= '0;
        end else if (i_en && i_valid && !is_proj) begin
            r_tab[i_word.coef_index] <= i_word.coef_value;
        end
    end

    // stage 1: twelve products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (i_en) r_v1 <= i_valid && is_proj;
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_prod[c][0] <= $signed(i_word.point_x) * $signed(r_tab[c]);
                r_prod[c][1] <= $signed(i_word.point_y) * $signed(r_tab[4 + c]);
                r_prod[c][2] <= $signed(i_word.point_z) * $signed(r_tab[8 + c]);
            end
            r_m33 <= $signed(r_tab[15]);
        end
    end

    // stage 2: sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (i_en) r_v2 <= r_v1;
        if (i_en) begin
            for (int c = 0; c < 3; c++)
                r_n[c] <= NUM_W'(r_prod[c][0]) + NUM_W'(r_prod[c][1])
                          + NUM_W'(r_prod[c][2]);
            r_w <= NUM_W'(r_prod[3][0]) + NUM_W'(r_prod[3][1]) + NUM_W'(r_prod[3][2])
                   + (NUM_W'(r_m33) <<< FRAC_BITS);
        end
    end

    assign o_valid = r_v2;
    assign o_n     = r_n;
    assign o_w     = r_w;
endmodule

// ===== sv/vpd_div.sv =====
// pipelined restoring divider for three lanes sharing one denominator
// depends on vpd_pkg
`include "vertex_projection_divide_defines.svh"
module vpd_div import vpd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [NUM_W-1:0] i_n [3],
    input  logic signed [NUM_W-1:0] i_w,
    output logic                    o_valid,
    output t_out_word               o_word
);
    logic      r_v    [DIV_STG+1];
    t_div_lane r_lane [DIV_STG+1][3];
    t_div_side r_side [DIV_STG+1];
    logic      r_ov;
    t_out_word r_out;

    // stage 0: magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (i_en) r_v[0] <= i_valid;
        if (i_en) begin
            r_side[0].dz  <= (i_w == '0);
            r_side[0].den <= i_w[NUM_W-1] ? NUM_W'(-i_w) : i_w;
            for (int l = 0; l < 3; l++) begin
                r_lane[0][l].num <= DIV_PAD'({(i_n[l][NUM_W-1] ? NUM_W'(-i_n[l]) : i_n[l]),
                                              FRAC_BITS'(0)});
                r_lane[0][l].rem <= '0;
                r_lane[0][l].quo <= '0;
                r_lane[0][l].neg <= i_n[l][NUM_W-1] ^ i_w[NUM_W-1];
            end
        end
    end

    // quotient stages, QSTEPS bits each
    for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
        t_div_lane n_lane [3];
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_lane[l] = r_lane[s][l];
                for (int k = 0; k < QSTEPS; k++) begin
                    n_lane[l].rem = {n_lane[l].rem[NUM_W-1:0], n_lane[l].num[DIV_PAD-1]};
                    n_lane[l].num = n_lane[l].num << 1;
                    n_lane[l].quo = n_lane[l].quo << 1;
                    if (n_lane[l].rem >= {1'b0, r_side[s].den}) begin
                        n_lane[l].rem    = n_lane[l].rem - {1'b0, r_side[s].den};
                        n_lane[l].quo[0] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s+1] <= 1'b0;
            else if (i_en) r_v[s+1] <= r_v[s];
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                for (int l = 0; l < 3; l++) r_lane[s+1][l] <= n_lane[l];
            end
        end
    end

    // final stage: sign, saturation, zero w
    always_comb begin
        t_div_lane q;
        logic [31:0] res [3];
        logic        sat;
        sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            q = r_lane[DIV_STG][l];
            if (q.neg) begin
                if (q.quo > DIV_PAD'(33'h0_8000_0000)) begin
                    res[l] = 32'h8000_0000; sat = 1'b1;
                end else res[l] = 32'(-q.quo[31:0]);
            end else begin
                if (q.quo > DIV_PAD'(32'h7FFF_FFFF)) begin
                    res[l] = 32'h7FFF_FFFF; sat = 1'b1;
                end else res[l] = q.quo[31:0];
            end
        end
        if (r_side[DIV_STG].dz) begin
            r_out = '0;
            r_out.divide_by_zero = 1'b1;
        end else begin
            r_out.proj_x = res[0];
            r_out.proj_y = res[1];
            r_out.proj_z = res[2];
            r_out.divide_by_zero = 1'b0;
            r_out.saturated = sat;
        end
    end

    assign r_ov    = r_v[DIV_STG];
    assign o_valid = r_ov;
    assign o_word  = r_out;

    `VPD_ASSERT(a_dz_zero, i_clk, i_rst_n, (o_valid && o_word.divide_by_zero) |-> (o_word.proj_x == '0 && o_word.proj_y == '0 && o_word.proj_z == '0 && !o_word.saturated), "zero w gave nonzero result")
endmodule

// ===== sv/vertex_projection_divide.sv =====
// Vertex projection with perspective divide. A load word writes one Q16.16
// coefficient; a project word yields one Q16.16 result after passing two dot
// product stages, the divider input stage, DIV_STG quotient stages of four
// quotient bits each and the output register. One word is taken every cycle
// while the pipeline moves; it stalls as a whole while the output register
// holds a word and o_out.ready is low.
// depends on vpd_pkg, vpd_if, vpd_dot, vpd_div
`include "vertex_projection_divide_defines.svh"
module vertex_projection_divide import vpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vpd_in_if.sink     i_in,
    vpd_out_if.source  o_out
);
    logic                    en, d_valid, p_valid;
    logic signed [NUM_W-1:0] d_n [3];
    logic signed [NUM_W-1:0] d_w;
    t_out_word               p_word;
    logic                    r_valid;
    t_out_word               r_word;

    // pipeline moves when the output register is free or drains
    assign en         = !r_valid || o_out.ready;
    assign i_in.ready = en;

    vpd_dot u_dot (.i_clk, .i_rst_n, .i_en(en), .i_valid(i_in.valid),
                   .i_word(i_in.data), .o_valid(d_valid), .o_n(d_n), .o_w(d_w));
    vpd_div u_div (.i_clk, .i_rst_n, .i_en(en), .i_valid(d_valid),
                   .i_n(d_n), .i_w(d_w), .o_valid(p_valid), .o_word(p_word));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (en) r_valid <= p_valid;
        if (en) r_word <= p_word;
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_word;

    `VPD_ASSERT(a_hold, i_clk, i_rst_n, (r_valid && !o_out.ready) |=> (r_valid && $stable(r_word)), "output word lost under stall")
    `VPD_ASSERT(a_rdy, i_clk, i_rst_n, (!r_valid) |-> i_in.ready, "input blocked with empty output")
    `VPD_ASSERT_RST(a_rst, i_clk, (!i_rst_n) |=> !o_out.valid, "valid after reset")
endmodule

// ===== tb/sv/vertex_projection_divide_tb.sv =====
// testbench for vertex_projection_divide: coefficient loads and point projections
// checked word by word against an exact fixed-point projection model
// depends on vpd_pkg, vpd_if and the block itself
`timescale 1ns / 100ps
module vertex_projection_divide_tb;
    import vpd_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_CYC   = 12;
    localparam int NUM_RANDOM  = 1500;
    localparam int DRAIN_CYC   = 60;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    vpd_in_if  in_ch ();
    vpd_out_if out_ch ();

    vertex_projection_divide uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // directed row: an input word, plus an optional typed-in expected result
    typedef struct {
        t_in_word  word;
        bit        has_fixed;
        t_out_word fixed;
    } t_row;

    logic signed [31:0] coef_table [16];
    t_out_word          proj_queue [$];
    int                 error_count = 0;
    int                 cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // cycle counter bounds the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // signed quotient: |n| << FRAC_BITS / |w| with the sign applied, clipped to 32 bits
    function automatic logic [31:0] divide_lane(input logic signed [67:0] num,
                                                input logic signed [67:0] den,
                                                inout bit clip);
        logic [67:0]  nmag;
        logic [67:0]  dmag;
        logic [127:0] q;
        bit           neg;
        logic [31:0]  lim;
        nmag = num[67] ? -num : num;
        dmag = den[67] ? -den : den;
        neg  = num[67] != den[67];
        q    = ({60'd0, nmag} << FRAC_BITS) / {60'd0, dmag};
        lim  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (q > {96'd0, lim}) begin
            clip = 1;
            return lim;
        end
        return neg ? 32'(-q[31:0]) : q[31:0];
    endfunction

    // applies one word to the local coefficient copy, queues any projection
    task automatic project_word(input t_in_word w);
        logic signed [67:0] px, py, pz, wsum;
        logic signed [67:0] n [3];
        t_out_word          r;
        bit                 clip;
        if (w.action == ACT_LOAD) begin
            coef_table[w.coef_index] = w.coef_value;
            return;
        end
        px   = 68'(signed'(w.point_x));
        py   = 68'(signed'(w.point_y));
        pz   = 68'(signed'(w.point_z));
        wsum = px * 68'(coef_table[3]) + py * 68'(coef_table[7]) + pz * 68'(coef_table[11])
               + (68'(coef_table[15]) <<< FRAC_BITS);
        for (int j = 0; j < 3; j++)
            n[j] = px * 68'(coef_table[j]) + py * 68'(coef_table[4 + j])
                   + pz * 68'(coef_table[8 + j]);
        r    = '0;
        clip = 0;
        if (wsum == 0) begin
            r.divide_by_zero = 1'b1;
        end else begin
            r.proj_x    = divide_lane(n[0], wsum, clip);
            r.proj_y    = divide_lane(n[1], wsum, clip);
            r.proj_z    = divide_lane(n[2], wsum, clip);
            r.saturated = clip;
        end
        proj_queue.push_back(r);
    endtask

    function automatic t_in_word load_word(input int idx, input logic [31:0] v);
        t_in_word w;
        w            = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
        w.action     = ACT_LOAD;
        w.coef_index = 4'(idx);
        w.coef_value = v;
        return w;
    endfunction

    function automatic t_in_word point_word(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z);
        t_in_word w;
        w            = t_in_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
        w.action     = ACT_PROJECT;
        w.point_x    = x;
        w.point_y    = y;
        w.point_z    = z;
        return w;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
            3: return 32'($signed($urandom_range(0, 2047)) - 1024) <<< 8;
            default: return $urandom;
        endcase
    endfunction

    // sender: bursts with random gaps, hands every accepted word to the model
    bit send_busy;
    int burst_left;
    task automatic send_word(input t_in_word w);
        while (send_busy == 0 && $urandom_range(0, 3) == 0 && burst_left == 0) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            if ($urandom_range(0, 2) == 0)
                burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        project_word(w);
    endtask

    // receiver stall pattern, with long stretches of always-ready
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= (cycle_count % 7) < 3;
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (proj_queue.size() == 0) begin
                report_mismatch("unexpected word", out_ch.data.proj_x, 32'd0);
            end else begin
                want = proj_queue.pop_front();
                if (out_ch.data.proj_x !== want.proj_x)
                    report_mismatch("proj_x", out_ch.data.proj_x, want.proj_x);
                if (out_ch.data.proj_y !== want.proj_y)
                    report_mismatch("proj_y", out_ch.data.proj_y, want.proj_y);
                if (out_ch.data.proj_z !== want.proj_z)
                    report_mismatch("proj_z", out_ch.data.proj_z, want.proj_z);
                if (out_ch.data.divide_by_zero !== want.divide_by_zero)
                    report_mismatch("divide_by_zero", 32'(out_ch.data.divide_by_zero),
                                    32'(want.divide_by_zero));
                if (out_ch.data.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(out_ch.data.saturated),
                                    32'(want.saturated));
            end
        end
    end

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    // stimulus
    initial begin
        t_row     rows [$];
        t_row     row;
        t_in_word w;
        int       shape;
        burst_left   = 0;
        send_busy    = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        for (int i = 0; i < 16; i++)
            coef_table[i] = '0;

        // after reset the table is zero, so w is zero
        row = '{point_word(ONE, ONE, ONE), 1, '{0, 0, 0, 1'b1, 1'b0}};
        rows.push_back(row);
        // identity with m33 = 1: projection returns the point
        row.has_fixed = 0;
        for (int i = 0; i < 4; i++) begin
            row.word = load_word(i * 5, ONE);
            rows.push_back(row);
        end
        rows.push_back('{point_word(MAXV, MINV, 32'h0003_8000), 1,
                         '{MAXV, MINV, 32'h0003_8000, 1'b0, 1'b0}});
        // translation row is stored but unused
        row.word = load_word(12, MAXV); rows.push_back(row);
        row.word = load_word(13, MINV); rows.push_back(row);
        row.word = load_word(14, 32'hDEAD_BEEF); rows.push_back(row);
        rows.push_back('{point_word(ONE, -ONE, 0), 1, '{ONE, -ONE, 0, 1'b0, 1'b0}});
        // tiny m33 forces saturation
        row.word = load_word(15, 32'h0000_0001); rows.push_back(row);
        rows.push_back('{point_word(MAXV, MINV, 0), 1, '{MAXV, MINV, 0, 1'b0, 1'b1}});
        // negative w and perspective column
        row.word = load_word(15, MINV); rows.push_back(row);
        row.word = load_word(11, MAXV); rows.push_back(row);
        row.word = load_word(3, MINV);  rows.push_back(row);
        row.word = point_word(MINV, MAXV, MINV); rows.push_back(row);
        row.word = point_word(0, 0, 0); rows.push_back(row);
        // w cancels to zero: m33 = -1, z*m23 = 1
        row.word = load_word(3, 0);     rows.push_back(row);
        row.word = load_word(11, ONE);  rows.push_back(row);
        row.word = load_word(15, -ONE); rows.push_back(row);
        rows.push_back('{point_word(MAXV, 32'h1234_5678, ONE), 1, '{0, 0, 0, 1'b1, 1'b0}});

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (rows[k]) begin
            if (rows[k].has_fixed) begin
                send_word(rows[k].word);
                void'(proj_queue.pop_back());
                proj_queue.push_back(rows[k].fixed);
            end else begin
                send_word(rows[k].word);
            end
        end

        // random: mostly point streams with occasional coefficient rewrites
        for (int n = 0; n < NUM_RANDOM; n++) begin
            shape = $urandom_range(0, 9);
            if (shape < 3)
                w = load_word($urandom_range(0, 15), rand_value());
            else
                w = point_word(rand_value(), rand_value(), rand_value());
            send_word(w);
        end
        in_ch.valid <= 1'b0;

        // drain
        while (proj_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
